FILE: rtl/ccpd_pkg.sv
// ----------------------------------------------------------------------------
// ccpd_pkg
// Types and constants shared by the command packet decoder modules.
// ----------------------------------------------------------------------------
package ccpd_pkg;

  // packet framing
  localparam logic [7:0]  PACKET_ID     = 8'h0a;
  localparam logic [7:0]  GROUP_SCRIPT  = 8'h00;
  localparam logic [7:0]  GROUP_CONTROL = 8'h20;
  localparam logic [2:0]  LAST_POS      = 3'd7;
  localparam logic [2:0]  MIN_LAST_POS  = 3'd6;
  localparam logic [15:0] LAST_SAMPLE   = 16'd501;
  localparam logic [15:0] LAST_SLOT     = 16'd15;

  // byte positions inside a packet
  localparam logic [2:0] POS_ID        = 3'd0;
  localparam logic [2:0] POS_GROUP     = 3'd1;
  localparam logic [2:0] POS_SELECTOR  = 3'd4;
  localparam logic [2:0] POS_ARG_LOW   = 3'd5;
  localparam logic [2:0] POS_ARG_HIGH  = 3'd6;

  // selectors
  localparam logic [7:0] SEL_0 = 8'd0;
  localparam logic [7:0] SEL_1 = 8'd1;
  localparam logic [7:0] SEL_2 = 8'd2;
  localparam logic [7:0] SEL_3 = 8'd3;
  localparam logic [7:0] SEL_4 = 8'd4;
  localparam logic [7:0] SEL_5 = 8'd5;
  localparam logic [7:0] SEL_6 = 8'd6;
  localparam logic [7:0] SEL_7 = 8'd7;
  localparam logic [7:0] SEL_8 = 8'd8;
  localparam logic [7:0] SEL_9 = 8'd9;

  // command kinds
  localparam logic [3:0] KIND_HOSTCAP    = 4'd0;
  localparam logic [3:0] KIND_XFERSTAT   = 4'd1;
  localparam logic [3:0] KIND_CAPS       = 4'd2;
  localparam logic [3:0] KIND_STEER      = 4'd3;
  localparam logic [3:0] KIND_FFB        = 4'd4;
  localparam logic [3:0] KIND_SAMPLES    = 4'd5;
  localparam logic [3:0] KIND_SLOT       = 4'd6;
  localparam logic [3:0] KIND_SCRIPTSTAT = 4'd7;
  localparam logic [3:0] KIND_VALUES     = 4'd8;
  localparam logic [3:0] KIND_AXES       = 4'd9;
  localparam logic [3:0] KIND_EXTSTAT    = 4'd10;

  // input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  // result transaction
  typedef struct packed {
    logic        accepted;
    logic [3:0]  kind;
    logic [15:0] argument;
  } out_t;

  // complete packet snapshot handed from capture to decode
  typedef struct packed {
    logic        length_ok;
    logic [7:0]  id_byte;
    logic [7:0]  group_byte;
    logic [7:0]  selector_byte;
    logic [15:0] param;
  } pkt_t;

endpackage

FILE: rtl/ccpd_capture.sv
// ----------------------------------------------------------------------------
// ccpd_capture
// Byte counter and field capture; registers a packet snapshot on the last byte.
// ----------------------------------------------------------------------------
module ccpd_capture (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  ccpd_pkg::in_t cmd,
  output logic          cmd_stall,
  output logic          pkt_valid,
  output ccpd_pkg::pkt_t pkt,
  input  logic          pkt_take
);
  import ccpd_pkg::*;

  logic [2:0] byte_count;
  logic [7:0] id_byte;
  logic [7:0] group_byte;
  logic [7:0] selector_byte;
  logic [7:0] arg_low;
  logic [7:0] arg_high;

  logic       take;
  pkt_t       pkt_next;

  // stall only while a finished packet cannot move on
  assign cmd_stall = pkt_valid && !pkt_take;
  assign take      = cmd_valid && !cmd_stall;

  // merge the current byte into the captured fields
  always_comb begin
    pkt_next.length_ok     = (byte_count >= MIN_LAST_POS);
    pkt_next.id_byte       = (byte_count == POS_ID)       ? cmd.data_byte : id_byte;
    pkt_next.group_byte    = (byte_count == POS_GROUP)    ? cmd.data_byte : group_byte;
    pkt_next.selector_byte = (byte_count == POS_SELECTOR) ? cmd.data_byte : selector_byte;
    pkt_next.param[7:0]    = (byte_count == POS_ARG_LOW)  ? cmd.data_byte : arg_low;
    pkt_next.param[15:8]   = (byte_count == POS_ARG_HIGH) ? cmd.data_byte : arg_high;
  end

  // saturating position counter
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (take) begin
      if (cmd.final_byte) begin
        byte_count <= '0;
      end else if (byte_count != LAST_POS) begin
        byte_count <= byte_count + 3'd1;
      end
    end
  end

  // captured packet bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      id_byte       <= '0;
      group_byte    <= '0;
      selector_byte <= '0;
      arg_low       <= '0;
      arg_high      <= '0;
    end else if (take) begin
      id_byte       <= pkt_next.id_byte;
      group_byte    <= pkt_next.group_byte;
      selector_byte <= pkt_next.selector_byte;
      arg_low       <= pkt_next.param[7:0];
      arg_high      <= pkt_next.param[15:8];
    end
  end

  // snapshot register for a complete packet
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
    end else if (take && cmd.final_byte) begin
      pkt_valid <= 1'b1;
    end else if (pkt_take) begin
      pkt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd.final_byte) begin
      pkt <= pkt_next;
    end
  end

endmodule

FILE: rtl/ccpd_decode.sv
// ----------------------------------------------------------------------------
// ccpd_decode
// Validates a captured packet, maps it to a command kind and registers the result.
// ----------------------------------------------------------------------------
module ccpd_decode (
  input  logic           clk,
  input  logic           rst,
  input  logic           pkt_valid,
  input  ccpd_pkg::pkt_t pkt,
  output logic           pkt_take,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ccpd_pkg::out_t rsp
);
  import ccpd_pkg::*;

  out_t dec;

  // result register can load when empty or draining
  assign pkt_take = !rsp_valid || !rsp_stall;

  // command decode
  always_comb begin
    dec = '0;
    if (pkt.length_ok && pkt.id_byte == PACKET_ID) begin
      if (pkt.group_byte == GROUP_CONTROL) begin
        case (pkt.selector_byte)
          SEL_0: begin
            dec.accepted = 1'b1;
            dec.kind     = KIND_HOSTCAP;
            dec.argument = {8'h00, pkt.param[7:0]};
          end
          SEL_1: begin
            dec.accepted = 1'b1;
            dec.kind     = KIND_XFERSTAT;
            dec.argument = pkt.param;
          end
          default: dec = '0;
        endcase
      end else if (pkt.group_byte == GROUP_SCRIPT) begin
        dec.accepted = 1'b1;
        dec.argument = pkt.param;
        case (pkt.selector_byte)
          SEL_0: dec.kind = KIND_CAPS;
          SEL_1: dec.kind = KIND_STEER;
          SEL_2: begin
            dec.kind     = KIND_FFB;
            dec.argument = {8'h00, pkt.param[7:0]};
          end
          SEL_3: dec.kind = KIND_XFERSTAT;
          SEL_4: dec.kind = KIND_SAMPLES;
          SEL_5: dec.kind = KIND_SLOT;
          SEL_6: dec.kind = KIND_SCRIPTSTAT;
          SEL_7: dec.kind = KIND_VALUES;
          SEL_8: dec.kind = KIND_AXES;
          SEL_9: dec.kind = KIND_EXTSTAT;
          default: dec.accepted = 1'b0;
        endcase
        // range checks on sample and slot parameters
        if (pkt.selector_byte == SEL_4 && pkt.param > LAST_SAMPLE) begin
          dec.accepted = 1'b0;
        end
        if (pkt.selector_byte == SEL_5 && pkt.param > LAST_SLOT) begin
          dec.accepted = 1'b0;
        end
        if (!dec.accepted) begin
          dec = '0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pkt_take) begin
      rsp_valid <= pkt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_take && pkt_valid) begin
      rsp <= dec;
    end
  end

endmodule

FILE: rtl/controller_command_packet_decoder_unit.sv
// ----------------------------------------------------------------------------
// controller_command_packet_decoder_unit
// Byte-serial command packet decoder: one result transaction per packet.
// ----------------------------------------------------------------------------
// Throughput: one byte transaction per cycle; the byte side stalls only while
//   a packet snapshot waits behind a stalled result.
// Path: the last byte loads the snapshot register, which then loads the result
//   register once that register is empty or draining.
// Reset: rst clears the byte count, captured bytes and both valid flags;
//   the first byte after reset is taken as byte zero.
module controller_command_packet_decoder_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  ccpd_pkg::in_t  cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ccpd_pkg::out_t rsp
);
  import ccpd_pkg::*;

  logic pkt_valid;
  logic pkt_take;
  pkt_t pkt;

  // byte capture and packet snapshot
  ccpd_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_stall (cmd_stall),
    .pkt_valid (pkt_valid),
    .pkt       (pkt),
    .pkt_take  (pkt_take)
  );

  // decode and result register
  ccpd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt       (pkt),
    .pkt_take  (pkt_take),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

FILE: rtl/ccpd_checker.sv
// ----------------------------------------------------------------------------
// ccpd_port_checker
// Port-level checks on the command packet decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ccpd_port_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input ccpd_pkg::in_t  cmd,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input ccpd_pkg::out_t rsp
);
  import ccpd_pkg::*;

  // a stalled result transaction stays and holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result transaction changed");

  // a refused packet reports zero kind and argument
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.accepted |-> rsp.kind == KIND_HOSTCAP && rsp.argument == 16'h0000)
    else $error("refused packet carries nonzero fields");

  // accepted kinds stay within the defined codes
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.accepted |-> rsp.kind <= KIND_EXTSTAT)
    else $error("accepted result has undefined kind");

  // byte-only parameters and range-limited parameters
  a_arg_limits: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.accepted |->
      ((rsp.kind != KIND_HOSTCAP && rsp.kind != KIND_FFB) || rsp.argument[15:8] == 8'h00) &&
      (rsp.kind != KIND_SAMPLES || rsp.argument <= LAST_SAMPLE) &&
      (rsp.kind != KIND_SLOT || rsp.argument <= LAST_SLOT))
    else $error("argument outside limits for its kind");

  // no result can appear without an earlier last byte transaction
  a_rsp_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd_valid && !cmd_stall && cmd.final_byte, 2) ||
      $past(rsp_valid || rsp_stall, 1) || $past(cmd_stall, 1))
    else $error("result transaction without a completed packet");

endmodule

bind controller_command_packet_decoder_unit ccpd_port_checker u_ccpd_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
